/* sv/weighted_window_sum_max_top_macros.svh */
// ----------------------------------------------------------------------------
// weighted window sum max - assertion macros
// shared helpers for the concurrent checks in the block's modules
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_WINDOW_SUM_MAX_TOP_MACROS_SVH
`define WEIGHTED_WINDOW_SUM_MAX_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define WWSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// consequent must hold in the cycle after the antecedent
`define WWSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WWSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define WWSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/wwsm_pkg.sv */
// ----------------------------------------------------------------------------
// wwsm_pkg
// constants and shared types of the weighted window sum maximum block
// ----------------------------------------------------------------------------
package wwsm_pkg;

    localparam int WINDOW_MAX   = 256;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_W        = 9;
    localparam int SUM_W        = 40;
    localparam int Q_DEPTH      = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    // classification of one sample, front to back
    typedef struct packed {
        logic steady;   // window already full, slide it
        logic load;     // this sample completes the first window
        logic last;     // final sample of the sequence
        logic full;     // a full window exists after this sample
    } t_item_ctl;

endpackage

/* sv/wwsm_ram.sv */
// ----------------------------------------------------------------------------
// wwsm_ram
// single port ram, read-before-write, registered read data
// ----------------------------------------------------------------------------
module wwsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/wwsm_front.sv */
// ----------------------------------------------------------------------------
// wwsm_front
// accepts samples, tracks window fill and ring position, weights the sample
// ----------------------------------------------------------------------------
`include "weighted_window_sum_max_top_macros.svh"

module wwsm_front #(
    parameter int WINDOW_MAX   = wwsm_pkg::WINDOW_MAX,
    parameter int SAMPLE_WIDTH = wwsm_pkg::SAMPLE_WIDTH,
    parameter int Q_DEPTH      = wwsm_pkg::Q_DEPTH,
    parameter int LEN_W        = $clog2(WINDOW_MAX + 1),
    parameter int PTR_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    parameter int PROD_W       = SAMPLE_WIDTH + LEN_W + 1,
    parameter int QCNT_W       = $clog2(Q_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [wwsm_pkg::CFG_W-1:0]     i_window_length,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last,
    input  logic [QCNT_W-1:0]              i_q_level,
    output logic                           o_push,
    output wwsm_pkg::t_item_ctl            o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_x,
    output logic signed [PROD_W-1:0]       o_prod,
    output logic signed [SAMPLE_WIDTH-1:0] o_old
);

    localparam int CMP_W = (LEN_W > wwsm_pkg::CFG_W) ? LEN_W : wwsm_pkg::CFG_W;

    logic [LEN_W-1:0]  r_seen;
    logic [LEN_W-1:0]  r_len;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_f1_valid;
    wwsm_pkg::t_item_ctl r_f1_ctl;
    logic signed [SAMPLE_WIDTH-1:0] r_f1_x;
    logic signed [PROD_W-1:0]       r_f1_prod;

    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  m_cur;
    logic [LEN_W-1:0]  seen_inc;
    logic [LEN_W-1:0]  coef;
    logic [LEN_W-1:0]  ptr_inc;
    logic              fill;
    logic              accept;
    logic [LEN_W-1:0]  n_seen;
    logic [PTR_W-1:0]  n_ptr;
    wwsm_pkg::t_item_ctl ctl;
    logic [QCNT_W:0]   in_flight;
    logic signed [SAMPLE_WIDTH-1:0] ram_rdata;

    // zero means one, anything past the ring depth saturates
    always_comb begin
        if (i_window_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (CMP_W'(i_window_length) > CMP_W'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = LEN_W'(i_window_length);
        end
    end

    // length is latched on the first beat of a sequence
    assign m_cur    = (r_seen == '0) ? eff_len : r_len;
    assign fill     = r_seen < m_cur;
    assign seen_inc = r_seen + LEN_W'(1);
    assign coef     = fill ? seen_inc : m_cur;
    assign ptr_inc  = LEN_W'(r_ptr) + LEN_W'(1);

    always_comb begin
        ctl.steady = !fill;
        ctl.load   = fill && (seen_inc == m_cur);
        ctl.last   = i_last;
        ctl.full   = !fill || (seen_inc == m_cur);
    end

    always_comb begin
        if (i_last) begin
            n_seen = '0;
            n_ptr  = '0;
        end else begin
            n_seen = fill ? seen_inc : r_seen;
            n_ptr  = (ptr_inc == m_cur) ? '0 : PTR_W'(ptr_inc);
        end
    end

    // keep a slot in the queue for every beat still in flight
    assign in_flight  = (QCNT_W+1)'(i_q_level) + (QCNT_W+1)'(r_f1_valid);
    assign o_in_stall = in_flight >= (QCNT_W+1)'(Q_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    wwsm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX),
        .ADDR_W(PTR_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_en   (accept),
        .i_we   (accept),
        .i_addr (r_ptr),
        .i_wdata(i_sample),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_len      <= '0;
            r_ptr      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (accept) begin
                r_seen <= n_seen;
                r_ptr  <= n_ptr;
                r_len  <= m_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_ctl  <= ctl;
            r_f1_x    <= i_sample;
            r_f1_prod <= $signed({1'b0, coef}) * i_sample;
        end
    end

    assign o_push = r_f1_valid;
    assign o_ctl  = r_f1_ctl;
    assign o_x    = r_f1_x;
    assign o_prod = r_f1_prod;
    assign o_old  = ram_rdata;

    `WWSM_ASSERT(a_ptr_in_window, i_clk, i_rst_n, (r_seen != '0) |-> (LEN_W'(r_ptr) < r_len), "ring pointer beyond window")
    `WWSM_ASSERT(a_seen_bounded, i_clk, i_rst_n, (r_seen != '0) |-> (r_seen <= r_len), "fill count beyond window")
    `WWSM_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, accept && i_last, (r_seen == '0) && (r_ptr == '0), "sequence not cleared after last beat")

endmodule

/* sv/wwsm_queue.sv */
// ----------------------------------------------------------------------------
// wwsm_queue
// short fifo that decouples the classifying front from the summing back
// ----------------------------------------------------------------------------
`include "weighted_window_sum_max_top_macros.svh"

module wwsm_queue #(
    parameter int DEPTH        = wwsm_pkg::Q_DEPTH,
    parameter int SAMPLE_WIDTH = wwsm_pkg::SAMPLE_WIDTH,
    parameter int PROD_W       = 26,
    parameter int QCNT_W       = $clog2(DEPTH + 1),
    parameter int QPTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  wwsm_pkg::t_item_ctl            i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [PROD_W-1:0]       i_prod,
    input  logic signed [SAMPLE_WIDTH-1:0] i_old,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [QCNT_W-1:0]              o_level,
    output wwsm_pkg::t_item_ctl            o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_x,
    output logic signed [PROD_W-1:0]       o_prod,
    output logic signed [SAMPLE_WIDTH-1:0] o_old
);

    wwsm_pkg::t_item_ctl            r_ctl  [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_x    [DEPTH];
    logic signed [PROD_W-1:0]       r_prod [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_old  [DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wptr]  <= i_ctl;
            r_x[r_wptr]    <= i_x;
            r_prod[r_wptr] <= i_prod;
            r_old[r_wptr]  <= i_old;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_level = r_count;
    assign o_ctl   = r_ctl[r_rptr];
    assign o_x     = r_x[r_rptr];
    assign o_prod  = r_prod[r_rptr];
    assign o_old   = r_old[r_rptr];

    `WWSM_ASSERT(a_q_overflow, i_clk, i_rst_n, i_push |-> ((r_count < QCNT_W'(DEPTH)) || i_pop), "push into full queue")
    `WWSM_ASSERT(a_q_underflow, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")

endmodule

/* sv/wwsm_back.sv */
// ----------------------------------------------------------------------------
// wwsm_back
// running weighted and window sums, maximum tracking and result register
// ----------------------------------------------------------------------------
`include "weighted_window_sum_max_top_macros.svh"

module wwsm_back #(
    parameter int SAMPLE_WIDTH = wwsm_pkg::SAMPLE_WIDTH,
    parameter int LEN_W        = 9,
    parameter int PROD_W       = SAMPLE_WIDTH + LEN_W + 1,
    parameter int WIN_W        = SAMPLE_WIDTH + LEN_W,
    parameter int ACC_W        = SAMPLE_WIDTH + 2 * LEN_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  wwsm_pkg::t_item_ctl               i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_x,
    input  logic signed [PROD_W-1:0]          i_prod,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_old,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [wwsm_pkg::SUM_W-1:0] o_best_sum,
    output logic                              o_valid_res
);

    logic signed [ACC_W-1:0] r_weighted;
    logic signed [WIN_W-1:0] r_window;
    logic                    r_a_valid;
    wwsm_pkg::t_item_ctl     r_a_ctl;
    logic signed [ACC_W-1:0] r_cand;
    logic signed [ACC_W-1:0] r_best;
    logic                    r_out_valid;
    logic signed [wwsm_pkg::SUM_W-1:0] r_out_sum;
    logic                    r_out_res;

    logic                    en;
    logic signed [ACC_W-1:0] w_new;
    logic signed [WIN_W-1:0] win_new;
    logic signed [ACC_W-1:0] n_best;

    // whole back end holds while a result waits on a stalled consumer
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && !i_empty;

    // sliding step subtracts the old window; filling step does not
    assign w_new   = r_weighted + ACC_W'(i_prod)
                   - (i_ctl.steady ? ACC_W'(r_window) : ACC_W'(0));
    assign win_new = r_window + WIN_W'(i_x)
                   - (i_ctl.steady ? WIN_W'(i_old) : WIN_W'(0));

    always_comb begin
        if (r_a_ctl.load) begin
            n_best = r_cand;
        end else if (r_a_ctl.steady && (r_cand > r_best)) begin
            n_best = r_cand;
        end else begin
            n_best = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weighted  <= '0;
            r_window    <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= o_pop;
            r_out_valid <= r_a_valid && r_a_ctl.last;
            if (o_pop) begin
                r_weighted <= i_ctl.last ? '0 : w_new;
                r_window   <= i_ctl.last ? '0 : win_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pop) begin
                r_a_ctl <= i_ctl;
                r_cand  <= w_new;
            end
            if (r_a_valid) begin
                r_best <= n_best;
                if (r_a_ctl.last) begin
                    r_out_sum <= r_a_ctl.full ? wwsm_pkg::SUM_W'(n_best) : '0;
                    r_out_res <= r_a_ctl.full;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_out_sum;
    assign o_valid_res = r_out_res;

    `WWSM_ASSERT(a_short_seq_zero, i_clk, i_rst_n, (r_out_valid && !r_out_res) |-> (r_out_sum == '0), "short sequence gave non-zero sum")

endmodule

/* sv/weighted_window_sum_max_top.sv */
// ----------------------------------------------------------------------------
// weighted_window_sum_max_top
// maximum of the linearly weighted moving sum over each flagged sequence
// ----------------------------------------------------------------------------
// Takes one signed sample per cycle while not stalled, no gaps of its own. For
// every window of M samples it forms 1*x0 + 2*x1 + ... + M*x(M-1) from a
// running weighted sum, a running window sum and a ring of the last M samples
// held in one single port ram (read old, write new, in a single access).
// The front latches M on the first beat of a sequence, weights the sample with
// one multiplier and passes it through a four entry queue to the back, which
// does the two sum updates and the maximum compare in consecutive stages. The
// result for a beat flagged last passes the front register, the queue, the compare
// stage and the result register; valid_res is low and best_sum zero if no full window was seen.
// While a result waits on a stalled consumer the back holds and up to four
// beats wait in the queue before the input stalls.
// Window length writes take effect from the next sequence; zero counts as one
// and values beyond the ring depth saturate. No clearing pass after reset.
// ----------------------------------------------------------------------------
module weighted_window_sum_max_top #(
    parameter int WINDOW_MAX   = wwsm_pkg::WINDOW_MAX,
    parameter int SAMPLE_WIDTH = wwsm_pkg::SAMPLE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wwsm_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [wwsm_pkg::SUM_W-1:0] o_best_sum,
    output logic                              o_valid_res
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int PROD_W = SAMPLE_WIDTH + LEN_W + 1;
    localparam int WIN_W  = SAMPLE_WIDTH + LEN_W;
    localparam int ACC_W  = SAMPLE_WIDTH + 2 * LEN_W;
    localparam int QCNT_W = $clog2(wwsm_pkg::Q_DEPTH + 1);

    logic [wwsm_pkg::CFG_W-1:0] r_window_length;

    logic [QCNT_W-1:0]              q_level;
    logic                           q_empty;
    logic                           push;
    logic                           pop;
    wwsm_pkg::t_item_ctl            f_ctl;
    logic signed [SAMPLE_WIDTH-1:0] f_x;
    logic signed [PROD_W-1:0]       f_prod;
    logic signed [SAMPLE_WIDTH-1:0] f_old;
    wwsm_pkg::t_item_ctl            q_ctl;
    logic signed [SAMPLE_WIDTH-1:0] q_x;
    logic signed [PROD_W-1:0]       q_prod;
    logic signed [SAMPLE_WIDTH-1:0] q_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= wwsm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_window_length <= i_cfg_wdata;
        end
    end

    wwsm_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .Q_DEPTH     (wwsm_pkg::Q_DEPTH),
        .LEN_W       (LEN_W),
        .PTR_W       (PTR_W),
        .PROD_W      (PROD_W),
        .QCNT_W      (QCNT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_length(r_window_length),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_q_level      (q_level),
        .o_push         (push),
        .o_ctl          (f_ctl),
        .o_x            (f_x),
        .o_prod         (f_prod),
        .o_old          (f_old)
    );

    wwsm_queue #(
        .DEPTH       (wwsm_pkg::Q_DEPTH),
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .PROD_W      (PROD_W),
        .QCNT_W      (QCNT_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_ctl  (f_ctl),
        .i_x    (f_x),
        .i_prod (f_prod),
        .i_old  (f_old),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_level(q_level),
        .o_ctl  (q_ctl),
        .o_x    (q_x),
        .o_prod (q_prod),
        .o_old  (q_old)
    );

    wwsm_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .LEN_W       (LEN_W),
        .PROD_W      (PROD_W),
        .WIN_W       (WIN_W),
        .ACC_W       (ACC_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_ctl      (q_ctl),
        .i_x        (q_x),
        .i_prod     (q_prod),
        .i_old      (q_old),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_best_sum (o_best_sum),
        .o_valid_res(o_valid_res)
    );

endmodule
